/* rtl/core/scpo_pkg.sv */
// Shared widths, register indexes and payload types for the sphere push-out block.
package scpo_pkg;

    localparam int CW     = 32;           // coordinate width
    localparam int EW     = 31;           // extent width
    localparam int DW     = CW + 1;       // signed center-minus-object difference
    localparam int MW     = CW;           // magnitude of the difference
    localparam int SQW    = 2 * EW + 2;   // sum of three extent squares
    localparam int LW     = SQW / 2;      // size vector length
    localparam int JW     = LW + 1;       // sum of two lengths (twice the radius sum)
    localparam int DSQW   = 2 * MW + 2;   // squared center distance
    localparam int GB     = 60 - CW;      // guard bits of the distance root
    localparam int QIN    = DSQW + 2 * GB;
    localparam int QW     = QIN / 2;      // guarded distance root
    localparam int PW     = MW + JW;      // |d| * J2
    localparam int NUMW   = PW + GB + 1;  // push-out dividend
    localparam int DENW   = QW + 1;       // push-out divisor
    localparam int OFW    = CW + 2;       // push-out offset
    localparam int RESW   = CW + 4;       // unsaturated result

    localparam int CFG_IW = 3;
    localparam int QD     = 4;            // queue depth
    localparam int QAW    = 2;
    localparam int QCW    = 3;

    localparam logic [CFG_IW-1:0] CFG_CX = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_CY = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_CZ = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_EX = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_EY = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_EZ = 3'd5;

    typedef struct packed {
        logic signed [CW-1:0] obj_x;
        logic signed [CW-1:0] obj_y;
        logic signed [CW-1:0] obj_z;
        logic [EW-1:0]        obj_extent_x;
        logic [EW-1:0]        obj_extent_y;
        logic [EW-1:0]        obj_extent_z;
    } t_item;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic signed [CW-1:0] out_z;
    } t_res;

    typedef struct packed {
        logic signed [CW-1:0] sphere_center_x;
        logic signed [CW-1:0] sphere_center_y;
        logic signed [CW-1:0] sphere_center_z;
        logic [EW-1:0]        sphere_extent_x;
        logic [EW-1:0]        sphere_extent_y;
        logic [EW-1:0]        sphere_extent_z;
    } t_cfg;

    // classified item handed from front to back; index 0 is x
    typedef struct packed {
        logic                   hit;
        logic [JW-1:0]          j2;
        logic [DSQW-1:0]        dsq;
        logic [2:0][MW-1:0]     dmag;
        logic [2:0]             dneg;
        logic [2:0][CW-1:0]     obj;
    } t_job;

endpackage

/* rtl/core/scpo_isqrt.sv */
// Pipelined integer square root, one root bit per stage, several lanes.
module scpo_isqrt #(
    parameter int IN_W  = 64,
    parameter int LANES = 1,
    parameter int TAG_W = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_vld,
    input  logic [LANES-1:0][IN_W-1:0]     i_rad,
    input  logic [TAG_W-1:0]               i_tag,
    output logic                           o_vld,
    output logic [LANES-1:0][IN_W/2-1:0]   o_root,
    output logic [TAG_W-1:0]               o_tag
);
    localparam int N  = IN_W / 2;
    localparam int RW = N + 2;

    logic                          r_vld  [1:N];
    logic [LANES-1:0][N-1:0]       r_root [1:N];
    logic [TAG_W-1:0]              r_tag  [1:N];
    logic [LANES-1:0][RW-1:0]      r_rem  [1:N-1];
    logic [LANES-1:0][IN_W-1:0]    r_x    [1:N-1];

    genvar k;
    for (k = 0; k < N; k++) begin : g_stage
        logic                       s_vld;
        logic [LANES-1:0][RW-1:0]   s_rem;
        logic [LANES-1:0][N-1:0]    s_root;
        logic [LANES-1:0][IN_W-1:0] s_x;
        logic [TAG_W-1:0]           s_tag;
        logic [LANES-1:0][RW-1:0]   n_rem;
        logic [LANES-1:0][N-1:0]    n_root;
        logic [LANES-1:0][IN_W-1:0] n_x;

        if (k == 0) begin : g_first
            assign s_vld  = i_vld;
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_x    = i_rad;
            assign s_tag  = i_tag;
        end else begin : g_next
            assign s_vld  = r_vld[k];
            assign s_rem  = r_rem[k];
            assign s_root = r_root[k];
            assign s_x    = r_x[k];
            assign s_tag  = r_tag[k];
        end

        always_comb begin
            logic [RW-1:0] sh;
            logic [RW-1:0] trial;
            logic          ge;
            for (int j = 0; j < LANES; j++) begin
                sh        = {s_rem[j][RW-3:0], s_x[j][IN_W-1 -: 2]};
                trial     = {s_root[j], 2'b01};
                ge        = (sh >= trial);
                n_rem[j]  = ge ? (sh - trial) : sh;
                n_root[j] = {s_root[j][N-2:0], ge};
                n_x[j]    = {s_x[j][IN_W-3:0], 2'b00};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= s_vld;
            end
            r_root[k+1] <= n_root;
            r_tag[k+1]  <= s_tag;
        end

        if (k < N - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[k+1] <= n_rem;
                r_x[k+1]   <= n_x;
            end
        end
    end

    assign o_vld  = r_vld[N];
    assign o_root = r_root[N];
    assign o_tag  = r_tag[N];

endmodule

/* rtl/core/scpo_div.sv */
// Pipelined restoring divider, one quotient bit per stage, lanes share one divisor.
module scpo_div #(
    parameter int NUM_W = 94,
    parameter int DEN_W = 62,
    parameter int Q_W   = 34,
    parameter int LANES = 3,
    parameter int TAG_W = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  logic [LANES-1:0][NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]             i_den,
    input  logic [TAG_W-1:0]             i_tag,
    output logic                         o_vld,
    output logic [LANES-1:0][Q_W-1:0]    o_quo,
    output logic [TAG_W-1:0]             o_tag
);
    localparam int RW = DEN_W + 1;

    logic                        r_vld [1:Q_W];
    logic [LANES-1:0][Q_W-1:0]   r_quo [1:Q_W];
    logic [TAG_W-1:0]            r_tag [1:Q_W];
    logic [LANES-1:0][RW-1:0]    r_rem [1:Q_W-1];
    logic [LANES-1:0][Q_W-1:0]   r_nlo [1:Q_W-1];
    logic [DEN_W-1:0]            r_den [1:Q_W-1];

    genvar k;
    for (k = 0; k < Q_W; k++) begin : g_stage
        logic                      s_vld;
        logic [LANES-1:0][RW-1:0]  s_rem;
        logic [LANES-1:0][Q_W-1:0] s_nlo;
        logic [LANES-1:0][Q_W-1:0] s_quo;
        logic [DEN_W-1:0]          s_den;
        logic [TAG_W-1:0]          s_tag;
        logic [LANES-1:0][RW-1:0]  n_rem;
        logic [LANES-1:0][Q_W-1:0] n_nlo;
        logic [LANES-1:0][Q_W-1:0] n_quo;

        if (k == 0) begin : g_first
            // quotient fits Q_W bits, so the top of the dividend is below the divisor
            always_comb begin
                for (int j = 0; j < LANES; j++) begin
                    s_rem[j] = RW'(i_num[j] >> Q_W);
                    s_nlo[j] = i_num[j][Q_W-1:0];
                end
            end
            assign s_vld = i_vld;
            assign s_quo = '0;
            assign s_den = i_den;
            assign s_tag = i_tag;
        end else begin : g_next
            assign s_vld = r_vld[k];
            assign s_rem = r_rem[k];
            assign s_nlo = r_nlo[k];
            assign s_quo = r_quo[k];
            assign s_den = r_den[k];
            assign s_tag = r_tag[k];
        end

        always_comb begin
            logic [RW-1:0] sh;
            logic          ge;
            for (int j = 0; j < LANES; j++) begin
                sh       = {s_rem[j][RW-2:0], s_nlo[j][Q_W-1]};
                ge       = (sh >= {1'b0, s_den});
                n_rem[j] = ge ? (sh - {1'b0, s_den}) : sh;
                n_nlo[j] = {s_nlo[j][Q_W-2:0], 1'b0};
                n_quo[j] = {s_quo[j][Q_W-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= s_vld;
            end
            r_quo[k+1] <= n_quo;
            r_tag[k+1] <= s_tag;
        end

        if (k < Q_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[k+1] <= n_rem;
                r_nlo[k+1] <= n_nlo;
                r_den[k+1] <= s_den;
            end
        end
    end

    assign o_vld = r_vld[Q_W];
    assign o_quo = r_quo[Q_W];
    assign o_tag = r_tag[Q_W];

endmodule

/* rtl/core/scpo_front.sv */
// Front end: radius lengths, center distance and the hit test.
module scpo_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_acc,
    input  scpo_pkg::t_item i_item,
    input  scpo_pkg::t_cfg i_cfg,
    output logic           o_push,
    output scpo_pkg::t_job o_job
);
    import scpo_pkg::*;

    typedef struct packed {
        logic [2:0]         dneg;
        logic [2:0][MW-1:0] dmag;
        logic [2:0][CW-1:0] obj;
    } t_ftag;

    logic [2:0][CW-1:0]        a_obj;
    logic [2:0][CW-1:0]        a_cen;
    logic [2:0][EW-1:0]        a_eo;
    logic [2:0][EW-1:0]        a_es;

    logic                      r_v1;
    logic [2:0][DW-1:0]        r_d;
    logic [2:0][2*EW-1:0]      r_esq_o;
    logic [2:0][2*EW-1:0]      r_esq_s;
    logic [2:0][CW-1:0]        r_obj1;

    logic                      r_v2;
    logic [1:0][SQW-1:0]       r_sums;
    t_ftag                     r_tag2;

    logic                      s_vld;
    logic [1:0][LW-1:0]        s_len;
    t_ftag                     s_tag;

    logic                      r_va;
    logic [JW-1:0]             r_j2;
    logic [2:0][2*MW-1:0]      r_dsq;
    t_ftag                     r_taga;

    logic                      r_vb;
    logic [JW-1:0]             r_j2b;
    logic [2*JW-1:0]           r_j2sq;
    logic [DSQW-1:0]           r_dsum;
    t_ftag                     r_tagb;

    assign a_obj = {i_item.obj_z, i_item.obj_y, i_item.obj_x};
    assign a_cen = {i_cfg.sphere_center_z, i_cfg.sphere_center_y, i_cfg.sphere_center_x};
    assign a_eo  = {i_item.obj_extent_z, i_item.obj_extent_y, i_item.obj_extent_x};
    assign a_es  = {i_cfg.sphere_extent_z, i_cfg.sphere_extent_y, i_cfg.sphere_extent_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_v1 <= i_acc;
            r_v2 <= r_v1;
            r_va <= s_vld;
            r_vb <= r_va;
        end

        for (int j = 0; j < 3; j++) begin
            r_d[j]     <= {a_cen[j][CW-1], a_cen[j]} - {a_obj[j][CW-1], a_obj[j]};
            r_esq_o[j] <= (2*EW)'(a_eo[j]) * (2*EW)'(a_eo[j]);
            r_esq_s[j] <= (2*EW)'(a_es[j]) * (2*EW)'(a_es[j]);
        end
        r_obj1 <= a_obj;

        for (int j = 0; j < 3; j++) begin
            r_tag2.dneg[j] <= r_d[j][DW-1];
            r_tag2.dmag[j] <= r_d[j][DW-1] ? MW'(-r_d[j]) : MW'(r_d[j]);
        end
        r_tag2.obj <= r_obj1;
        r_sums[0]  <= SQW'(r_esq_o[0]) + SQW'(r_esq_o[1]) + SQW'(r_esq_o[2]);
        r_sums[1]  <= SQW'(r_esq_s[0]) + SQW'(r_esq_s[1]) + SQW'(r_esq_s[2]);

        r_j2   <= JW'(s_len[0]) + JW'(s_len[1]);
        for (int j = 0; j < 3; j++) begin
            r_dsq[j] <= (2*MW)'(s_tag.dmag[j]) * (2*MW)'(s_tag.dmag[j]);
        end
        r_taga <= s_tag;

        r_j2b  <= r_j2;
        r_j2sq <= (2*JW)'(r_j2) * (2*JW)'(r_j2);
        r_dsum <= DSQW'(r_dsq[0]) + DSQW'(r_dsq[1]) + DSQW'(r_dsq[2]);
        r_tagb <= r_taga;
    end

    // lane 0: object size vector, lane 1: sphere size vector
    scpo_isqrt #(
        .IN_W  (SQW),
        .LANES (2),
        .TAG_W ($bits(t_ftag))
    ) u_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_v2),
        .i_rad   (r_sums),
        .i_tag   (r_tag2),
        .o_vld   (s_vld),
        .o_root  (s_len),
        .o_tag   (s_tag)
    );

    // touching counts as a hit: 4*D <= J2^2
    always_comb begin
        o_job.hit  = ({r_dsum, 2'b00} <= (DSQW+2)'(r_j2sq));
        o_job.j2   = r_j2b;
        o_job.dsq  = r_dsum;
        o_job.dmag = r_tagb.dmag;
        o_job.dneg = r_tagb.dneg;
        o_job.obj  = r_tagb.obj;
    end

    assign o_push = r_vb;

endmodule

/* rtl/core/scpo_queue.sv */
// Small job queue between front and back.
module scpo_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  scpo_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_vld,
    output logic           o_full,
    output scpo_pkg::t_job o_job
);
    import scpo_pkg::*;

    t_job           r_mem [QD];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_vld   = (r_cnt != '0);
    assign o_full  = (r_cnt == QCW'(QD));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

/* rtl/core/scpo_back.sv */
// Back end: guarded distance root, push-out divide and saturation.
module scpo_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  scpo_pkg::t_job i_job,
    input  scpo_pkg::t_cfg i_cfg,
    output logic           o_pop,
    output logic           o_strobe,
    output scpo_pkg::t_res o_res
);
    import scpo_pkg::*;

    typedef struct packed {
        logic [2:0]         dneg;
        logic               hit;
        logic               zero;
        logic [JW-1:0]      j2;
        logic [2:0][CW-1:0] obj;
    } t_side;

    typedef struct packed {
        logic [2:0][PW-1:0] prod;
        t_side              side;
    } t_btag;

    function automatic logic [CW-1:0] sat(input logic signed [RESW-1:0] v);
        logic [CW-1:0] r;
        if (v[RESW-1:CW-1] == '0 || v[RESW-1:CW-1] == '1) begin
            r = v[CW-1:0];
        end else if (v[RESW-1]) begin
            r = {1'b1, {(CW-1){1'b0}}};
        end else begin
            r = {1'b0, {(CW-1){1'b1}}};
        end
        return r;
    endfunction

    logic                  r_v1;
    logic [0:0][QIN-1:0]   r_sq_in;
    t_btag                 r_tag1;

    logic                  s_qv;
    logic [0:0][QW-1:0]    s_q;
    t_btag                 s_qtag;

    logic                  r_v2;
    logic [2:0][NUMW-1:0]  r_num;
    logic [DENW-1:0]       r_den;
    t_side                 r_side2;

    logic                  s_dv;
    logic [2:0][OFW-1:0]   s_off;
    t_side                 s_dside;

    logic                  r_strobe;
    t_res                  r_res;

    logic [2:0][CW-1:0]    a_cen;
    logic [2:0][CW-1:0]    n_out;

    assign o_pop = i_vld;
    assign a_cen = {i_cfg.sphere_center_z, i_cfg.sphere_center_y, i_cfg.sphere_center_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_v1     <= i_vld;
            r_v2     <= s_qv;
            r_strobe <= s_dv;
        end

        r_sq_in[0] <= {i_job.dsq, {(2*GB){1'b0}}};
        for (int j = 0; j < 3; j++) begin
            r_tag1.prod[j] <= PW'(i_job.dmag[j]) * PW'(i_job.j2);
        end
        r_tag1.side.dneg <= i_job.dneg;
        r_tag1.side.hit  <= i_job.hit;
        r_tag1.side.zero <= (i_job.dsq == '0);
        r_tag1.side.j2   <= i_job.j2;
        r_tag1.side.obj  <= i_job.obj;

        // round half up: (|d|*J2*2^G + q) / 2q
        for (int j = 0; j < 3; j++) begin
            r_num[j] <= NUMW'({s_qtag.prod[j], {GB{1'b0}}}) + NUMW'(s_q[0]);
        end
        r_den   <= {s_q[0], 1'b0};
        r_side2 <= s_qtag.side;

        r_res.hit   <= s_dside.hit;
        r_res.out_x <= n_out[0];
        r_res.out_y <= n_out[1];
        r_res.out_z <= n_out[2];
    end

    scpo_isqrt #(
        .IN_W  (QIN),
        .LANES (1),
        .TAG_W ($bits(t_btag))
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_v1),
        .i_rad   (r_sq_in),
        .i_tag   (r_tag1),
        .o_vld   (s_qv),
        .o_root  (s_q),
        .o_tag   (s_qtag)
    );

    scpo_div #(
        .NUM_W (NUMW),
        .DEN_W (DENW),
        .Q_W   (OFW),
        .LANES (3),
        .TAG_W ($bits(t_side))
    ) u_push (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_v2),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_tag   (r_side2),
        .o_vld   (s_dv),
        .o_quo   (s_off),
        .o_tag   (s_dside)
    );

    always_comb begin
        logic signed [RESW-1:0] c_e;
        logic signed [RESW-1:0] off_e;
        logic signed [RESW-1:0] v;
        logic [JW:0]            half;
        half = ({1'b0, s_dside.j2} + (JW+1)'(1)) >> 1;
        for (int j = 0; j < 3; j++) begin
            c_e   = RESW'(signed'(a_cen[j]));
            off_e = signed'(RESW'(s_off[j]));
            if (!s_dside.hit) begin
                v = RESW'(signed'(s_dside.obj[j]));
            end else if (s_dside.zero) begin
                // coincident centers: drop straight down by the radius sum
                v = (j == 1) ? (c_e - signed'(RESW'(half))) : c_e;
            end else begin
                v = s_dside.dneg[j] ? (c_e + off_e) : (c_e - off_e);
            end
            n_out[j] = sat(v);
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

/* rtl/core/sphere_collision_push_out.sv */
// Top level of the sphere-sphere collision push-out block.
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+---------------------------
//  item in   | start, busy                    | i_item (t_item)
//  result    | o_res_strobe (one cycle)       | o_res (t_res)
//  config    | i_cfg_valid, o_cfg_ready       | i_cfg_idx, i_cfg_data
//
// One item per cycle while busy is low; the result strobe follows the accepting edge through
// the 32-stage length roots, the 61-stage distance root and the 34-stage divider.
// Synchronous active-low reset clears the valid bits, queue pointers and count, and config registers to zero.
// busy rises only when the front-to-back queue is full; the back drains it every cycle.
// Results cannot be held off, so nothing downstream ever stalls the pipe.
module sphere_collision_push_out (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  scpo_pkg::t_item                 i_item,
    output logic                            o_res_strobe,
    output scpo_pkg::t_res                  o_res,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [scpo_pkg::CFG_IW-1:0]     i_cfg_idx,
    input  logic [scpo_pkg::CW-1:0]         i_cfg_data
);
    import scpo_pkg::*;

    t_cfg r_cfg;
    logic acc;
    logic q_push;
    t_job q_in;
    logic q_vld;
    logic q_full;
    t_job q_out;
    logic q_pop;

    assign o_cfg_ready = 1'b1;
    assign busy        = q_full;
    assign acc         = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_idx)
                CFG_CX:  r_cfg.sphere_center_x <= i_cfg_data;
                CFG_CY:  r_cfg.sphere_center_y <= i_cfg_data;
                CFG_CZ:  r_cfg.sphere_center_z <= i_cfg_data;
                CFG_EX:  r_cfg.sphere_extent_x <= i_cfg_data[EW-1:0];
                CFG_EY:  r_cfg.sphere_extent_y <= i_cfg_data[EW-1:0];
                CFG_EZ:  r_cfg.sphere_extent_z <= i_cfg_data[EW-1:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    scpo_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .o_push  (q_push),
        .o_job   (q_in)
    );

    scpo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_vld   (q_vld),
        .o_full  (q_full),
        .o_job   (q_out)
    );

    scpo_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (q_vld),
        .i_job    (q_out),
        .i_cfg    (r_cfg),
        .o_pop    (q_pop),
        .o_strobe (o_res_strobe),
        .o_res    (o_res)
    );

endmodule

/* rtl/core/scpo_chk.sv */
// Port-level checks for the sphere push-out block, bound to the top level.
module scpo_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_cfg_valid,
    input logic o_cfg_ready,
    input logic o_res_strobe
);

    // reset empties the pipe and the queue
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_strobe && !busy)
        else $error("strobe or busy after reset");

    // no result can come out right after reset without any earlier transaction
    a_no_early_res: assert property (@(posedge i_clk)
        !i_rst_n ##1 !start |=> !o_res_strobe)
        else $error("result without a transaction");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write stalled");

endmodule

bind sphere_collision_push_out scpo_chk u_scpo_chk (.*);
